@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

    // operand selection for the shared modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC,
        OP_SQUARE
    } t_mul_op;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    mul_start;
        t_mul_op mul_op;
        logic    shift_exp;
        logic    emit;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic exp_bit;
        logic exp_zero;
        logic mod_small;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/mexp_ctrl.sv @@
`default_nettype none

module mexp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire mexp_pkg::t_dp_stat i_stat,
    output mexp_pkg::t_dp_cmd       o_cmd
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_RED_WAIT,
        S_BIT,
        S_ACC_WAIT,
        S_SQ_WAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    o_cmd.load = 1'b1;
                    n_busy     = 1'b1;
                    n_state    = i_stat.mod_small ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = OP_REDUCE;
                n_state         = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                // stop as soon as no set exponent bit remains
                if (i_stat.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.exp_bit) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = OP_ACC;
                    n_state         = S_ACC_WAIT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = OP_SQUARE;
                    n_state         = S_SQ_WAIT;
                end
            end
            S_ACC_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = OP_SQUARE;
                    n_state         = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_BIT;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_busy     = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

@@ hdl/mexp_dp.sv @@
`default_nettype none

module mexp_dp #(
    parameter int WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [WIDTH-1:0]   i_base,
    input  wire logic [WIDTH-1:0]   i_exponent,
    input  wire logic               i_modulus_we,
    input  wire logic [WIDTH-1:0]   i_modulus,
    input  wire mexp_pkg::t_dp_cmd  i_cmd,
    output mexp_pkg::t_dp_stat      o_stat,
    output logic [WIDTH-1:0]        o_power,
    output logic                    o_done
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);
    localparam int WX = WIDTH + 2;
    localparam logic [CW-1:0] STEPS = CW'(WIDTH);
    localparam logic [CW-1:0] LAST  = CW'(1);
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_power;
    logic             r_done;

    // shared shift-add modular multiplier
    logic [WIDTH-1:0] r_mx;
    logic [WIDTH-1:0] r_my;
    logic [WIDTH-1:0] r_macc;
    logic [CW-1:0]    r_mcnt;
    logic             r_mbusy;
    logic             r_mdone;
    t_mul_op          r_mop;

    logic [WIDTH-1:0] w_opx, w_opy;
    logic [WX-1:0]    w_sum, w_m1, w_m2, w_red;
    logic             w_last;

    // operand selection at multiplier start
    always_comb begin
        case (i_cmd.mul_op)
            OP_REDUCE: begin
                w_opx = ONE;
                w_opy = r_base;
            end
            OP_ACC: begin
                w_opx = r_acc;
                w_opy = r_sq;
            end
            OP_SQUARE: begin
                w_opx = r_sq;
                w_opy = r_sq;
            end
            default: begin
                w_opx = r_sq;
                w_opy = r_sq;
            end
        endcase
    end

    // one multiplier step: 2*acc plus x if the bit is set, below 3m, then reduce
    always_comb begin
        w_sum = {1'b0, r_macc, 1'b0} + (r_my[WIDTH-1] ? {2'b00, r_mx} : '0);
        w_m1  = {2'b00, r_mod};
        w_m2  = {1'b0, r_mod, 1'b0};
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
    end

    assign w_last = r_mbusy && (r_mcnt == LAST);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= WIDTH'(2);
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_modulus_we) begin
                r_mod <= i_modulus;
            end
            r_mdone <= 1'b0;
            r_done  <= i_cmd.emit;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= STEPS;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - LAST;
                if (w_last) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base;
            r_e    <= i_exponent;
            r_acc  <= ONE;
        end else if (i_cmd.shift_exp) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.mul_start) begin
            r_mx   <= w_opx;
            r_my   <= w_opy;
            r_macc <= '0;
            r_mop  <= i_cmd.mul_op;
        end else if (r_mbusy) begin
            r_macc <= w_red[WIDTH-1:0];
            r_my   <= r_my << 1;
            if (w_last) begin
                if (r_mop == OP_ACC) begin
                    r_acc <= w_red[WIDTH-1:0];
                end else begin
                    r_sq <= w_red[WIDTH-1:0];
                end
            end
        end
        if (i_cmd.emit) begin
            r_power <= o_stat.mod_small ? '0 : r_acc;
        end
    end

    // status back to the controller
    assign o_stat.mul_done  = r_mdone;
    assign o_stat.exp_bit   = r_e[0];
    assign o_stat.exp_zero  = ~|r_e;
    assign o_stat.mod_small = ~|r_mod[WIDTH-1:1];

    assign o_power = r_power;
    assign o_done  = r_done;

endmodule

`default_nettype wire

@@ hdl/modular_exponentiation.sv @@
// the shared shift-add multiplier first reduces the base; then for each exponent bit the
// controller tests the bit, multiplies into the accumulator if it is set, and squares
// a zero exponent gives one after the reduction alone; modulus below two skips the multiplier and gives zero
// throughput: one item at a time, the next is taken the cycle busy is low again
// o_done strobes for one cycle with o_power; the receiver cannot stall
// synchronous active-low reset sets modulus to 2 and returns to idle
`default_nettype none

module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [WIDTH-1:0] i_base,
    input  wire logic [WIDTH-1:0] i_exponent,
    input  wire logic             i_modulus_we,
    input  wire logic [WIDTH-1:0] i_modulus,
    output logic [WIDTH-1:0]      o_power,
    output logic                  o_done
);
    import mexp_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // registers and modular multiplier
    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_base       (i_base),
        .i_exponent   (i_exponent),
        .i_modulus_we (i_modulus_we),
        .i_modulus    (i_modulus),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_power      (o_power),
        .o_done       (o_done)
    );

endmodule

`default_nettype wire

@@ hdl/mexp_chk.sv @@
`default_nettype none
`include "assert_macros.svh"

module mexp_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done
);

    // an accepted item makes the block busy
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // a result appears exactly as busy drops
    `ASSERT_IMPLIES(a_done_ends_busy, i_clk, i_rst_n, o_done, $fell(busy))

    // the result strobe lasts one cycle
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

endmodule

bind modular_exponentiation mexp_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

`default_nettype wire
